FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers. Checks compile away when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check sampled on the rising clock edge, off while reset is held low.
`define AFT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");

// Check sampled on every rising clock edge, reset included.
`define AFT_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: check failed");

`else

`define AFT_ASSERT(lbl, clk, rst_n, prop)
`define AFT_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

FILE: rtl/aft_pkg.sv
// ----------------------------------------------------------------------------
// aft_pkg
// Shared types and constants for the aging flow table.
// ----------------------------------------------------------------------------
package aft_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int ADDR_W          = 32;
    localparam int HITS_W          = 32;

    localparam logic [HITS_W-1:0] HITS_MAX = '1;

    localparam logic ACT_LOOKUP = 1'b0;
    localparam logic ACT_SWEEP  = 1'b1;

    // Probe that walks the cell row, one cell per cycle.
    typedef struct packed {
        logic              vld;
        logic              sweep;
        logic              found;
        logic              inserted;
        logic [ADDR_W-1:0] addr;
        logic [HITS_W-1:0] hits;
    } t_probe;

    // Entry contents as seen by the neighboring cells during compaction.
    typedef struct packed {
        logic              vld;
        logic [ADDR_W-1:0] addr;
        logic [HITS_W-1:0] hits;
    } t_entry;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_PACK,
        ST_FINISH
    } t_state;

endpackage

FILE: rtl/aft_cell.sv
// ----------------------------------------------------------------------------
// aft_cell
// One table entry. Serves the probe passing through it and takes part in
// the compaction shift with its two neighbors.
// ----------------------------------------------------------------------------
module aft_cell import aft_pkg::*; #(
    parameter int IDX_W    = 6,
    parameter int CNT_W    = 7,
    parameter int CELL_IDX = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_probe           i_tok,
    input  logic [IDX_W-1:0] i_tok_idx,
    input  logic [CNT_W-1:0] i_tok_kept,
    input  logic             i_pack,
    input  logic             i_prev_vld,
    input  t_entry           i_next,
    output t_probe           o_tok,
    output logic [IDX_W-1:0] o_tok_idx,
    output logic [CNT_W-1:0] o_tok_kept,
    output t_entry           o_entry
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic              r_vld;
    logic              r_recent;
    logic [ADDR_W-1:0] r_addr;
    logic [HITS_W-1:0] r_hits;

    t_probe            r_tok;
    logic [IDX_W-1:0]  r_tok_idx;
    logic [CNT_W-1:0]  r_tok_kept;

    t_probe            n_tok;
    logic [IDX_W-1:0]  n_tok_idx;
    logic [CNT_W-1:0]  n_tok_kept;

    logic              w_lookup;
    logic              w_hit;
    logic              w_ins;
    logic              w_sweep;
    logic              w_keep;
    logic              w_pull;
    logic [HITS_W-1:0] w_hits_inc;

    always_comb begin
        w_lookup   = i_tok.vld && !i_tok.sweep && !i_tok.found;
        w_hit      = w_lookup && r_vld && (r_addr == i_tok.addr);
        // entries are contiguous, so the first empty cell is the append slot
        w_ins      = w_lookup && !r_vld;
        w_sweep    = i_tok.vld && i_tok.sweep;
        w_keep     = r_vld && r_recent;
        w_pull     = i_pack && !r_vld;
        w_hits_inc = (r_hits == HITS_MAX) ? r_hits : r_hits + HITS_W'(1);
    end

    // valid / age mark
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= 1'b0;
            r_recent <= 1'b0;
        end else if (w_hit) begin
            r_recent <= 1'b1;
        end else if (w_ins) begin
            r_vld    <= 1'b1;
            r_recent <= 1'b1;
        end else if (w_sweep) begin
            r_recent <= 1'b0;
            if (!w_keep) begin
                r_vld <= 1'b0;
            end
        end else if (w_pull) begin
            r_vld <= i_next.vld;
        end else if (i_pack && !i_prev_vld) begin
            // handed our entry down to the empty cell below
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_hit) begin
            r_hits <= w_hits_inc;
        end else if (w_ins) begin
            r_addr <= i_tok.addr;
            r_hits <= HITS_W'(1);
        end else if (w_pull) begin
            r_addr <= i_next.addr;
            r_hits <= i_next.hits;
        end
    end

    always_comb begin
        n_tok      = i_tok;
        n_tok_idx  = i_tok_idx;
        n_tok_kept = i_tok_kept;
        if (w_hit) begin
            n_tok.found = 1'b1;
            n_tok.hits  = w_hits_inc;
            n_tok_idx   = MY_IDX;
        end else if (w_ins) begin
            n_tok.found    = 1'b1;
            n_tok.inserted = 1'b1;
            n_tok.hits     = HITS_W'(1);
            n_tok_idx      = MY_IDX;
        end else if (w_sweep && w_keep) begin
            n_tok_kept = i_tok_kept + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok_idx  <= n_tok_idx;
        r_tok_kept <= n_tok_kept;
    end

    always_comb begin
        o_tok        = r_tok;
        o_tok_idx    = r_tok_idx;
        o_tok_kept   = r_tok_kept;
        o_entry.vld  = r_vld;
        o_entry.addr = r_addr;
        o_entry.hits = r_hits;
    end

endmodule

FILE: rtl/aft_chain.sv
// ----------------------------------------------------------------------------
// aft_chain
// Row of table cells. The probe enters at cell 0 and leaves after the last
// cell; compaction moves entries one cell down per cycle.
// ----------------------------------------------------------------------------
module aft_chain import aft_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int IDX_W       = 6,
    parameter int CNT_W       = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_probe           i_tok,
    input  logic [IDX_W-1:0] i_tok_idx,
    input  logic [CNT_W-1:0] i_tok_kept,
    input  logic             i_pack,
    output t_probe           o_tok,
    output logic [IDX_W-1:0] o_tok_idx,
    output logic [CNT_W-1:0] o_tok_kept
);

    t_probe           w_tok  [0:TABLE_DEPTH];
    logic [IDX_W-1:0] w_idx  [0:TABLE_DEPTH];
    logic [CNT_W-1:0] w_kept [0:TABLE_DEPTH];
    t_entry           w_ent  [0:TABLE_DEPTH-1];

    assign w_tok[0]  = i_tok;
    assign w_idx[0]  = i_tok_idx;
    assign w_kept[0] = i_tok_kept;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        t_entry w_next;
        logic   w_prev_vld;

        if (g == TABLE_DEPTH - 1) begin : g_top
            assign w_next = '0;
        end else begin : g_mid
            assign w_next = w_ent[g+1];
        end

        if (g == 0) begin : g_bot
            assign w_prev_vld = 1'b1;
        end else begin : g_up
            assign w_prev_vld = w_ent[g-1].vld;
        end

        aft_cell #(
            .IDX_W    (IDX_W),
            .CNT_W    (CNT_W),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_tok      (w_tok[g]),
            .i_tok_idx  (w_idx[g]),
            .i_tok_kept (w_kept[g]),
            .i_pack     (i_pack),
            .i_prev_vld (w_prev_vld),
            .i_next     (w_next),
            .o_tok      (w_tok[g+1]),
            .o_tok_idx  (w_idx[g+1]),
            .o_tok_kept (w_kept[g+1]),
            .o_entry    (w_ent[g])
        );
    end

    assign o_tok      = w_tok[TABLE_DEPTH];
    assign o_tok_idx  = w_idx[TABLE_DEPTH];
    assign o_tok_kept = w_kept[TABLE_DEPTH];

endmodule

FILE: rtl/aging_flow_table.sv
// ----------------------------------------------------------------------------
// aging_flow_table
// Flow table keyed by peer address with age marks, saturating hit counters
// and compaction on sweep. One item is in flight at a time. A lookup walks a
// probe through the row of TABLE_DEPTH cells, one cell per cycle; its result
// becomes valid in the same cycle that the next beat can be taken. A sweep
// takes the same walk to drop aged entries and count survivors, then the row
// shifts survivors down one cell per cycle while in the pack state. The
// output register holds a finished result while the next beat is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module aging_flow_table import aft_pkg::*; #(
    parameter  int TABLE_DEPTH = TABLE_DEPTH_DEF,
    localparam int IDX_W       = $clog2(TABLE_DEPTH),
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_action,
    input  logic [ADDR_W-1:0] i_peer_address,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [IDX_W-1:0]  o_flow_index,
    output logic              o_was_inserted,
    output logic              o_table_full,
    output logic [HITS_W-1:0] o_hit_count,
    output logic [CNT_W-1:0]  o_entry_count,
    output logic [CNT_W-1:0]  o_removed_count
);

    localparam int               PK_W    = $clog2(TABLE_DEPTH);
    localparam logic [PK_W-1:0]  PK_LAST = PK_W'(TABLE_DEPTH - 1);

    t_state            r_state;
    t_state            n_state;
    t_probe            r_tok;
    logic [CNT_W-1:0]  r_count;
    logic [PK_W-1:0]   r_pk_cnt;
    logic [PK_W-1:0]   n_pk_cnt;

    logic [IDX_W-1:0]  r_res_idx;
    logic              r_res_ins;
    logic              r_res_full;
    logic [HITS_W-1:0] r_res_hits;
    logic [CNT_W-1:0]  r_res_removed;

    logic              r_out_vld;
    logic [IDX_W-1:0]  r_out_idx;
    logic              r_out_ins;
    logic              r_out_full;
    logic [HITS_W-1:0] r_out_hits;
    logic [CNT_W-1:0]  r_out_count;
    logic [CNT_W-1:0]  r_out_removed;

    t_probe            w_tail;
    logic [IDX_W-1:0]  w_tail_idx;
    logic [CNT_W-1:0]  w_tail_kept;
    logic              w_accept;
    logic              w_done;
    logic              w_pack;
    logic              w_load;

    aft_chain #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_chain (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tok      (r_tok),
        .i_tok_idx  ('0),
        .i_tok_kept ('0),
        .i_pack     (w_pack),
        .o_tok      (w_tail),
        .o_tok_idx  (w_tail_idx),
        .o_tok_kept (w_tail_kept)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_pk_cnt = r_pk_cnt;
        w_accept = 1'b0;
        w_done   = 1'b0;
        w_pack   = 1'b0;
        w_load   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    w_accept = 1'b1;
                    n_state  = ST_WALK;
                end
            end
            ST_WALK: begin
                if (w_tail.vld) begin
                    w_done   = 1'b1;
                    n_pk_cnt = '0;
                    n_state  = w_tail.sweep ? ST_PACK : ST_FINISH;
                end
            end
            ST_PACK: begin
                // survivors shift down toward their slots while the pack counter runs to PK_LAST
                w_pack = 1'b1;
                if (r_pk_cnt == PK_LAST) begin
                    n_state = ST_FINISH;
                end else begin
                    n_pk_cnt = r_pk_cnt + PK_W'(1);
                end
            end
            ST_FINISH: begin
                if (!r_out_vld || !i_stall) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != ST_IDLE);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok     <= '0;
            r_count   <= '0;
            r_pk_cnt  <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_pk_cnt <= n_pk_cnt;
            if (w_accept) begin
                r_tok.vld      <= 1'b1;
                r_tok.sweep    <= (i_action == ACT_SWEEP);
                r_tok.found    <= 1'b0;
                r_tok.inserted <= 1'b0;
                r_tok.addr     <= i_peer_address;
                r_tok.hits     <= '0;
            end else begin
                r_tok <= '0;
            end
            if (w_done) begin
                if (w_tail.sweep) begin
                    r_count <= w_tail_kept;
                end else if (w_tail.inserted) begin
                    r_count <= r_count + CNT_W'(1);
                end
            end
            if (w_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // result capture
    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_res_ins     <= 1'b0;
            r_res_full    <= 1'b0;
            r_res_idx     <= '0;
            r_res_hits    <= '0;
            r_res_removed <= '0;
            if (w_tail.sweep) begin
                r_res_removed <= r_count - w_tail_kept;
            end else if (w_tail.found) begin
                r_res_idx  <= w_tail_idx;
                r_res_hits <= w_tail.hits;
                r_res_ins  <= w_tail.inserted;
            end else begin
                r_res_full <= 1'b1;
            end
        end
        if (w_load) begin
            r_out_idx     <= r_res_idx;
            r_out_ins     <= r_res_ins;
            r_out_full    <= r_res_full;
            r_out_hits    <= r_res_hits;
            r_out_count   <= r_count;
            r_out_removed <= r_res_removed;
        end
    end

    assign o_valid         = r_out_vld;
    assign o_flow_index    = r_out_idx;
    assign o_was_inserted  = r_out_ins;
    assign o_table_full    = r_out_full;
    assign o_hit_count     = r_out_hits;
    assign o_entry_count   = r_out_count;
    assign o_removed_count = r_out_removed;

    `AFT_ASSERT(a_tail_in_walk, i_clk, i_rst_n, w_tail.vld |-> r_state == ST_WALK)
    `AFT_ASSERT(a_miss_means_full, i_clk, i_rst_n, (w_tail.vld && !w_tail.sweep && !w_tail.found) |-> r_count == CNT_W'(TABLE_DEPTH))
    `AFT_ASSERT(a_insert_has_room, i_clk, i_rst_n, (w_tail.vld && w_tail.inserted) |-> r_count < CNT_W'(TABLE_DEPTH))
    `AFT_ASSERT(a_load_after_finish, i_clk, i_rst_n, w_load |=> (o_valid && r_state == ST_IDLE))

endmodule
